/* rtl/mpdf_pkg.sv */
// Shared types and constants of the mesh packet duplicate filter.
// No dependencies; imported by the filter and its checker.
`default_nettype none

package mpdf_pkg;

    // Fixed header geometry and configuration reset values
    localparam int unsigned HEADER_BYTES = 12;

    localparam logic [7:0]  OWN_ID_RST    = 8'd1;
    localparam logic [7:0]  BCAST_RST     = 8'd255;
    localparam logic [7:0]  SYNC_A_RST    = 8'd170;
    localparam logic [7:0]  SYNC_B_RST    = 8'd85;
    localparam logic [31:0] TTL_RST       = 32'd30000;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ID  = 3'd0,
        CFG_BCAST   = 3'd1,
        CFG_SYNC_A  = 3'd2,
        CFG_SYNC_B  = 3'd3,
        CFG_TTL     = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        VD_SHORT    = 3'd0,
        VD_BAD_SYNC = 3'd1,
        VD_DUP      = 3'd2,
        VD_ACCEPT   = 3'd3,
        VD_SENT     = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESOLVE
    } t_state;

    // One slot of the seen-packet cache
    typedef struct packed {
        logic [7:0]  src;
        logic [31:0] id;
        logic [31:0] stamp;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/mesh_packet_dedup_filter.sv */
// Receive-side duplicate filter for a flooding mesh: cache, sequencer, config registers.
// Depends on mpdf_pkg.
`default_nettype none

// Usage
//   Command channel: drive the header fields (or a sent-packet note with
//   i_func high) and raise start; the word is taken at the edge where start
//   is high and busy is low. Exactly one result word follows, shown on the
//   o_ result ports for a single cycle with o_strobe high.
//   Flow: a sent-packet note, a too-short header or a bad sync gives its
//   result in the cycle after acceptance, and busy stays low, so such words
//   may follow every cycle. A header that reaches the cache lookup keeps busy
//   high while the scan state reads one cache slot per cycle through
//   the single registered read port and checks it in one shared compare unit
//   (source, id and a 32-bit age subtract against the TTL); then the drain
//   state settles the last compare and the resolve state forms the verdict
//   and, on a miss, writes the slot. The result shows in the cycle busy falls.
//   The receiver cannot stall: it must take the word while o_strobe is high.
//   Configuration: i_cfg_valid with i_cfg_index/i_cfg_data; o_cfg_ready is
//   always high. Write only while idle. Unknown indexes are ignored.
//   Reset (i_rst_n low, synchronous) clears all valid bits and the write
//   pointer at once and loads the register defaults; no clearing pass.

module mesh_packet_dedup_filter
    import mpdf_pkg::*;
#(
    parameter int unsigned DEDUP_ENTRIES = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_func,
    input  wire logic [7:0]            i_source_id,
    input  wire logic [7:0]            i_dest_addr,
    input  wire logic [31:0]           i_packet_id,
    input  wire logic [2:0]            i_hop_limit,
    input  wire logic [7:0]            i_sync_first,
    input  wire logic [7:0]            i_sync_second,
    input  wire logic [7:0]            i_packet_len,
    input  wire logic [31:0]           i_now_ms,
    // result
    output logic                       o_strobe,
    output logic [2:0]                 o_verdict,
    output logic                       o_for_us,
    output logic                       o_relay,
    output logic [2:0]                 o_relay_hop_limit,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W = (DEDUP_ENTRIES > 1) ? $clog2(DEDUP_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEDUP_ENTRIES - 1);
    localparam logic [7:0] MIN_LEN = 8'(HEADER_BYTES);

    // configuration registers
    logic [7:0]  r_own_id;
    logic [7:0]  r_bcast;
    logic [7:0]  r_sync_a;
    logic [7:0]  r_sync_b;
    logic [31:0] r_ttl;

    // sequencer and cache control
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_scan_addr, n_scan_addr;
    logic [IDX_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic               r_cmp_pend, n_cmp_pend;
    logic               r_hit, n_hit;
    logic [DEDUP_ENTRIES-1:0] r_valid;

    // latched header under lookup
    logic [7:0]  r_src;
    logic [7:0]  r_dst;
    logic [31:0] r_id;
    logic [2:0]  r_hops;
    logic [31:0] r_now;
    logic        ld_item;

    // cache storage and its registered read port
    t_entry      mem [DEDUP_ENTRIES];
    t_entry      r_rd_data;
    logic        r_rd_valid;
    logic        wr_en;
    t_entry      wr_data;

    // result registers
    logic        r_strobe, n_strobe;
    t_verdict    r_verdict, n_verdict;
    logic        r_for_us, n_for_us;
    logic        r_relay, n_relay;
    logic [2:0]  r_relay_hops, n_relay_hops;

    logic        len_ok;
    logic        sync_ok;
    logic        scan_last;
    logic [31:0] age;
    logic        match;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_strobe          = r_strobe;
    assign o_verdict         = r_verdict;
    assign o_for_us          = r_for_us;
    assign o_relay           = r_relay;
    assign o_relay_hop_limit = r_relay_hops;

    assign len_ok    = (i_packet_len >= MIN_LEN);
    assign sync_ok   = (i_sync_first == r_sync_a) && (i_sync_second == r_sync_b);
    assign scan_last = (r_scan_addr == LAST_IDX);

    // the shared compare unit: one slot per cycle, wrapping age against TTL
    assign age   = r_now - r_rd_data.stamp;
    assign match = r_cmp_pend && r_rd_valid && (r_rd_data.src == r_src) &&
                   (r_rd_data.id == r_id) && (age < r_ttl);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= OWN_ID_RST;
            r_bcast  <= BCAST_RST;
            r_sync_a <= SYNC_A_RST;
            r_sync_b <= SYNC_B_RST;
            r_ttl    <= TTL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OWN_ID: r_own_id <= i_cfg_data[7:0];
                CFG_BCAST:  r_bcast  <= i_cfg_data[7:0];
                CFG_SYNC_A: r_sync_a <= i_cfg_data[7:0];
                CFG_SYNC_B: r_sync_b <= i_cfg_data[7:0];
                CFG_TTL:    r_ttl    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && !i_func && len_ok && sync_ok) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:   n_state = ST_RESOLVE;
            ST_RESOLVE: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath control and result forming
    always_comb begin
        n_strobe     = 1'b0;
        n_verdict    = r_verdict;
        n_for_us     = r_for_us;
        n_relay      = r_relay;
        n_relay_hops = r_relay_hops;
        n_scan_addr  = r_scan_addr;
        n_cmp_pend   = 1'b0;
        n_hit        = r_hit;
        ld_item      = 1'b0;
        wr_en        = 1'b0;
        wr_data      = '{src: r_src, id: r_id, stamp: r_now};
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_for_us     = 1'b0;
                    n_relay      = 1'b0;
                    n_relay_hops = 3'd0;
                    if (i_func) begin
                        // own transmission: note it so echoes are dropped
                        wr_en     = 1'b1;
                        wr_data   = '{src: r_own_id, id: i_packet_id, stamp: i_now_ms};
                        n_strobe  = 1'b1;
                        n_verdict = VD_SENT;
                    end else if (!len_ok) begin
                        n_strobe  = 1'b1;
                        n_verdict = VD_SHORT;
                    end else if (!sync_ok) begin
                        n_strobe  = 1'b1;
                        n_verdict = VD_BAD_SYNC;
                    end else begin
                        ld_item     = 1'b1;
                        n_scan_addr = '0;
                        n_hit       = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                n_cmp_pend = 1'b1;
                n_hit      = r_hit | match;
                if (!scan_last) begin
                    n_scan_addr = r_scan_addr + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                n_hit = r_hit | match;
            end
            ST_RESOLVE: begin
                n_strobe = 1'b1;
                if (r_hit) begin
                    n_verdict = VD_DUP;
                end else begin
                    wr_en     = 1'b1;
                    n_verdict = VD_ACCEPT;
                    n_for_us  = (r_dst == r_own_id) || (r_dst == r_bcast);
                    if ((r_hops != 3'd0) && (r_dst != r_own_id)) begin
                        n_relay      = 1'b1;
                        n_relay_hops = r_hops - 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign n_wr_ptr = !wr_en ? r_wr_ptr :
                      (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + IDX_W'(1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_addr <= '0;
            r_wr_ptr    <= '0;
            r_cmp_pend  <= 1'b0;
            r_hit       <= 1'b0;
            r_strobe    <= 1'b0;
            r_verdict   <= VD_SHORT;
            r_for_us    <= 1'b0;
            r_relay     <= 1'b0;
            r_relay_hops <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_scan_addr <= n_scan_addr;
            r_wr_ptr    <= n_wr_ptr;
            r_cmp_pend  <= n_cmp_pend;
            r_hit       <= n_hit;
            r_strobe    <= n_strobe;
            r_verdict   <= n_verdict;
            r_for_us    <= n_for_us;
            r_relay     <= n_relay;
            r_relay_hops <= n_relay_hops;
        end
    end

    // valid bits, cleared together at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_wr_ptr] <= 1'b1;
        end
    end

    // header hold registers
    always_ff @(posedge i_clk) begin
        if (ld_item) begin
            r_src  <= i_source_id;
            r_dst  <= i_dest_addr;
            r_id   <= i_packet_id;
            r_hops <= i_hop_limit;
            r_now  <= i_now_ms;
        end
    end

    // cache memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wr_ptr] <= wr_data;
        end
        r_rd_data  <= mem[r_scan_addr];
        r_rd_valid <= r_valid[r_scan_addr];
    end

endmodule

`default_nettype wire

/* rtl/mpdf_checker.sv */
// Port-level checks for the mesh packet duplicate filter, bound to its top level.
// Depends on mpdf_pkg and mesh_packet_dedup_filter.
`default_nettype none

module mpdf_checker
    import mpdf_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  i_func,
    input wire logic                  o_strobe,
    input wire logic [2:0]            o_verdict,
    input wire logic                  o_for_us,
    input wire logic                  o_relay,
    input wire logic [2:0]            o_relay_hop_limit
);

    // an accepted word is either still being looked up or answered next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted word neither busy nor answered");

    // a lookup only ends by showing its result
    a_busy_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy fell without a result");

    // a sent-packet note is always answered with the sent verdict
    a_sent_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func) |=> (o_strobe && (o_verdict == VD_SENT)))
        else $error("sent-packet note answered wrongly");

    // only accepted headers carry delivery or relay information
    a_flags_accept_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_verdict != VD_ACCEPT)) |->
            (!o_for_us && !o_relay && (o_relay_hop_limit == 3'd0)))
        else $error("flags set on a non-accepted word");

    // no result without a word accepted or under lookup in the previous cycle
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start)))
        else $error("result without a command");

endmodule

bind mesh_packet_dedup_filter mpdf_checker u_mpdf_checker (.*);

`default_nettype wire

/* dv/mpdf_filter_checker.sv */
// Checker for the mesh packet duplicate filter: watches the command, result and
// config channels, predicts every result word and compares it. Depends on mpdf_pkg.
`timescale 1ns / 1ps

module mpdf_filter_checker
    import mpdf_pkg::*;
#(
    parameter int unsigned DEDUP_ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  i_func,
    input  logic [7:0]            i_source_id,
    input  logic [7:0]            i_dest_addr,
    input  logic [31:0]           i_packet_id,
    input  logic [2:0]            i_hop_limit,
    input  logic [7:0]            i_sync_first,
    input  logic [7:0]            i_sync_second,
    input  logic [7:0]            i_packet_len,
    input  logic [31:0]           i_now_ms,
    input  logic                  o_strobe,
    input  logic [2:0]            o_verdict,
    input  logic                  o_for_us,
    input  logic                  o_relay,
    input  logic [2:0]            o_relay_hop_limit,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatch_count,
    output int                    o_words_pending
);

    typedef struct packed {
        t_verdict   verdict;
        logic       for_us;
        logic       relay;
        logic [2:0] relay_hops;
    } t_filter_word;

    logic [7:0]   own_id;
    logic [7:0]   bcast_id;
    logic [7:0]   sync_a;
    logic [7:0]   sync_b;
    logic [31:0]  ttl_ms;

    logic [7:0]   slot_src   [DEDUP_ENTRIES];
    logic [31:0]  slot_id    [DEDUP_ENTRIES];
    logic [31:0]  slot_stamp [DEDUP_ENTRIES];
    logic         slot_live  [DEDUP_ENTRIES];
    int unsigned  wr_slot;

    t_filter_word due_q[$];

    // Hit needs a live slot, same source and id, age below TTL in wrapping time
    function automatic logic seen_recently(input logic [7:0] src, input logic [31:0] id,
                                           input logic [31:0] now);
        logic [31:0] age;
        for (int k = 0; k < DEDUP_ENTRIES; k++) begin
            age = now - slot_stamp[k];
            if (slot_live[k] && slot_src[k] == src && slot_id[k] == id && age < ttl_ms)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void remember(input logic [7:0] src, input logic [31:0] id,
                                     input logic [31:0] now);
        slot_src[wr_slot]   = src;
        slot_id[wr_slot]    = id;
        slot_stamp[wr_slot] = now;
        slot_live[wr_slot]  = 1'b1;
        wr_slot = (wr_slot + 1) % DEDUP_ENTRIES;
    endfunction

    function automatic t_filter_word judge_word(
        input logic        func,
        input logic [7:0]  src,
        input logic [7:0]  dst,
        input logic [31:0] id,
        input logic [2:0]  hops,
        input logic [7:0]  s0,
        input logic [7:0]  s1,
        input logic [7:0]  len,
        input logic [31:0] now
    );
        t_filter_word w;
        w = '0;
        if (func) begin
            remember(own_id, id, now);
            w.verdict = VD_SENT;
        end else if (len < HEADER_BYTES) begin
            w.verdict = VD_SHORT;
        end else if (s0 != sync_a || s1 != sync_b) begin
            w.verdict = VD_BAD_SYNC;
        end else if (seen_recently(src, id, now)) begin
            w.verdict = VD_DUP;
        end else begin
            remember(src, id, now);
            w.verdict = VD_ACCEPT;
            w.for_us  = (dst == own_id) || (dst == bcast_id);
            if (hops != 3'd0 && dst != own_id) begin
                w.relay      = 1'b1;
                w.relay_hops = hops - 3'd1;
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_filter_word got;
        t_filter_word want;
        if (!i_rst_n) begin
            own_id   = OWN_ID_RST;
            bcast_id = BCAST_RST;
            sync_a   = SYNC_A_RST;
            sync_b   = SYNC_B_RST;
            ttl_ms   = TTL_RST;
            for (int k = 0; k < DEDUP_ENTRIES; k++) begin
                slot_src[k]   = '0;
                slot_id[k]    = '0;
                slot_stamp[k] = '0;
                slot_live[k]  = 1'b0;
            end
            wr_slot = 0;
            due_q.delete();
        end else begin
            // results first, so a word taken at this edge cannot pair with itself
            if (o_strobe) begin
                got.verdict    = t_verdict'(o_verdict);
                got.for_us     = o_for_us;
                got.relay      = o_relay;
                got.relay_hops = o_relay_hop_limit;
                if (due_q.size() == 0) begin
                    if (o_mismatch_count < 10)
                        $display({"%0t: unexpected result word: ",
                                  "verdict %0d for_us %0b relay %0b hops %0d"},
                                 $time, o_verdict, o_for_us, o_relay, o_relay_hop_limit);
                    o_mismatch_count = o_mismatch_count + 1;
                end else begin
                    want = due_q.pop_front();
                    if (got !== want) begin
                        if (o_mismatch_count < 10)
                            $display({"%0t: result mismatch: exp verdict %0d for_us %0b ",
                                      "relay %0b hops %0d, got %0d %0b %0b %0d"},
                                     $time, want.verdict, want.for_us, want.relay,
                                     want.relay_hops, o_verdict, o_for_us, o_relay,
                                     o_relay_hop_limit);
                        o_mismatch_count = o_mismatch_count + 1;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OWN_ID: own_id   = i_cfg_data[7:0];
                    CFG_BCAST:  bcast_id = i_cfg_data[7:0];
                    CFG_SYNC_A: sync_a   = i_cfg_data[7:0];
                    CFG_SYNC_B: sync_b   = i_cfg_data[7:0];
                    CFG_TTL:    ttl_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                due_q.push_back(judge_word(i_func, i_source_id, i_dest_addr, i_packet_id,
                                           i_hop_limit, i_sync_first, i_sync_second,
                                           i_packet_len, i_now_ms));
        end
        o_words_pending = due_q.size();
    end

endmodule

/* dv/tb_mesh_packet_dedup_filter.sv */
// Top of the mesh packet duplicate filter testbench: clock, reset, stimulus and verdict.
// Depends on mpdf_pkg, mesh_packet_dedup_filter and mpdf_filter_checker.
`timescale 1ns / 1ps

module tb_mesh_packet_dedup_filter;
    import mpdf_pkg::*;

    localparam int unsigned SLOTS           = 16;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned WORDS_PER_PHASE = 125;
    localparam int unsigned SETTLE_CYCLES   = 25;   // comfortably past a full lookup
    localparam int unsigned POOL_DEPTH      = 24;   // deeper than the ring, so evictions show
    localparam int unsigned MAX_GAP         = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_func = 1'b0;
    logic [7:0]            i_source_id = '0;
    logic [7:0]            i_dest_addr = '0;
    logic [31:0]           i_packet_id = '0;
    logic [2:0]            i_hop_limit = '0;
    logic [7:0]            i_sync_first = '0;
    logic [7:0]            i_sync_second = '0;
    logic [7:0]            i_packet_len = '0;
    logic [31:0]           i_now_ms = '0;
    logic                  o_strobe;
    logic [2:0]            o_verdict;
    logic                  o_for_us;
    logic                  o_relay;
    logic [2:0]            o_relay_hop_limit;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int mismatches;
    int pending;

    // Stimulus-side view of the settings, used only to shape the words
    logic [7:0]  cur_own    = OWN_ID_RST;
    logic [7:0]  cur_bcast  = BCAST_RST;
    logic [7:0]  cur_sync_a = SYNC_A_RST;
    logic [7:0]  cur_sync_b = SYNC_B_RST;
    logic [31:0] cur_ttl    = TTL_RST;
    logic [31:0] base_ms    = '0;
    int unsigned idle_pct   = 0;

    // Recently recorded source/id/time triples, replayed to provoke duplicates
    t_entry recent_q[$];

    always #1 i_clk = ~i_clk;

    mesh_packet_dedup_filter #(
        .DEDUP_ENTRIES (SLOTS)
    ) u_top (
        .*
    );

    mpdf_filter_checker #(
        .DEDUP_ENTRIES (SLOTS)
    ) u_checker (
        .o_mismatch_count (mismatches),
        .o_words_pending  (pending),
        .*
    );

    // Watchdog: a hung handshake or a lost result ends the run here
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_mesh_packet_dedup_filter failed");
        $finish;
    end

    // One register write; valid is left high so writes can run back to back
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input logic [7:0] own, input logic [7:0] bcast,
                                  input logic [7:0] sa, input logic [7:0] sb,
                                  input logic [31:0] ttl, input logic spare);
        set_reg(CFG_OWN_ID, 32'(own));
        set_reg(CFG_BCAST,  32'(bcast));
        set_reg(CFG_SYNC_A, 32'(sa));
        set_reg(CFG_SYNC_B, 32'(sb));
        set_reg(CFG_TTL,    ttl);
        // unused indexes must be ignored by the block
        if (spare) begin
            for (int k = int'(CFG_TTL) + 1; k < (1 << CFG_IDX_W); k++)
                set_reg(CFG_IDX_W'(k), $urandom);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cur_own    = own;
        cur_bcast  = bcast;
        cur_sync_a = sa;
        cur_sync_b = sb;
        cur_ttl    = ttl;
    endtask

    // Present one command word, optionally after an idle gap, and hold it until taken
    task automatic drive_word(input logic        func,
                              input logic [7:0]  src,
                              input logic [7:0]  dst,
                              input logic [31:0] id,
                              input logic [2:0]  hops,
                              input logic [7:0]  s0,
                              input logic [7:0]  s1,
                              input logic [7:0]  len,
                              input logic [31:0] now);
        t_entry seen;
        if ($urandom_range(0, 99) < idle_pct) begin
            repeat ($urandom_range(1, MAX_GAP)) begin
                @(negedge i_clk);
                start = 1'b0;
            end
        end
        @(negedge i_clk);
        start         = 1'b1;
        i_func        = func;
        i_source_id   = src;
        i_dest_addr   = dst;
        i_packet_id   = id;
        i_hop_limit   = hops;
        i_sync_first  = s0;
        i_sync_second = s1;
        i_packet_len  = len;
        i_now_ms      = now;
        do @(posedge i_clk); while (busy);
        // anything that could land in the cache goes into the replay pool
        seen.id    = id;
        seen.stamp = now;
        seen.src   = func ? cur_own : src;
        if (func || (len >= HEADER_BYTES && s0 == cur_sync_a && s1 == cur_sync_b)) begin
            recent_q.push_back(seen);
            if (recent_q.size() > POOL_DEPTH)
                void'(recent_q.pop_front());
        end
    endtask

    // Drop start and wait until every result word is in, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Time for a replayed word: straddle the TTL edge, stay close, or go anywhere
    function automatic logic [31:0] near_stamp(input logic [31:0] stamp);
        case ($urandom_range(0, 5))
            0: return stamp;
            1: return stamp + $urandom_range(0, 50);
            2: return stamp + cur_ttl - 32'd1;
            3: return stamp + cur_ttl;
            4: return stamp + cur_ttl + 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed headers, a good share replaying earlier traffic;
    // the rest sent-packet notes, short frames and bad sync.
    task automatic random_word();
        int unsigned pick;
        t_entry      seen;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [31:0] id;
        logic [31:0] now;
        logic [2:0]  hops;
        logic [7:0]  s0;
        logic [7:0]  s1;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            base_ms = $urandom;
        else
            base_ms = base_ms + $urandom_range(0, 40);
        case ($urandom_range(0, 3))
            0: dst = cur_own;
            1: dst = cur_bcast;
            default: dst = 8'($urandom);
        endcase
        hops = 3'($urandom_range(0, 7));
        if (recent_q.size() != 0 && $urandom_range(0, 1) == 1) begin
            seen = recent_q[$urandom_range(0, recent_q.size() - 1)];
            src  = seen.src;
            id   = seen.id;
            now  = near_stamp(seen.stamp);
        end else begin
            src = ($urandom_range(0, 4) == 0) ? cur_own : 8'($urandom);
            // a narrow id range now and then gives accidental collisions
            id  = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
            now = base_ms;
        end
        if (pick < 15) begin
            // other fields are don't-care for a sent note
            drive_word(1'b1, 8'($urandom), 8'($urandom), id, 3'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), now);
        end else if (pick < 23) begin
            s0 = ($urandom_range(0, 1) == 1) ? cur_sync_a : 8'($urandom);
            s1 = ($urandom_range(0, 1) == 1) ? cur_sync_b : 8'($urandom);
            drive_word(1'b0, src, dst, id, hops, s0, s1,
                       8'($urandom_range(0, HEADER_BYTES - 1)), now);
        end else if (pick < 31) begin
            case ($urandom_range(0, 2))
                0: begin
                    s0 = cur_sync_a ^ 8'($urandom_range(1, 255));
                    s1 = cur_sync_b;
                end
                1: begin
                    s0 = cur_sync_a;
                    s1 = cur_sync_b ^ 8'($urandom_range(1, 255));
                end
                default: begin
                    s0 = 8'($urandom);
                    s1 = 8'($urandom);
                end
            endcase
            drive_word(1'b0, src, dst, id, hops, s0, s1,
                       8'($urandom_range(HEADER_BYTES, 255)), now);
        end else begin
            drive_word(1'b0, src, dst, id, hops, cur_sync_a, cur_sync_b,
                       8'($urandom_range(HEADER_BYTES, 255)), now);
        end
    endtask

    // Settings per phase: defaults, both extremes, own id equal to broadcast,
    // tiny and odd TTLs, writes to unused indexes, fully random settings, and back to defaults.
    task automatic configure_phase(input int unsigned ph);
        logic [7:0] shared_id;
        shared_id = 8'($urandom);
        case (ph)
            0: apply_settings(OWN_ID_RST, BCAST_RST, SYNC_A_RST, SYNC_B_RST, TTL_RST, 1'b0);
            1: apply_settings(8'h00, 8'hFF, 8'h00, 8'hFF, 32'd0, 1'b0);
            2: apply_settings(8'hFF, 8'h00, 8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b0);
            3: apply_settings(shared_id, shared_id, 8'($urandom), 8'($urandom), 32'd1, 1'b0);
            4: apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              32'd100, 1'b0);
            5: apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              32'd5000, 1'b1);
            6: apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              $urandom, 1'b0);
            default: apply_settings(OWN_ID_RST, BCAST_RST, SYNC_A_RST, SYNC_B_RST, TTL_RST,
                                    1'b0);
        endcase
    endtask

    initial begin : stimulus
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words under the reset settings
        // length checked before sync: short frame with good, then bad, sync bytes
        drive_word(1'b0, 8'h00, 8'h00, 32'd0, 3'd0, SYNC_A_RST, SYNC_B_RST, 8'd0, 32'd0);
        drive_word(1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'h00, 8'hFF,
                   8'(HEADER_BYTES - 1), 32'hFFFF_FFFF);
        // bad first sync at the minimum length, bad second sync at the maximum
        drive_word(1'b0, 8'h10, 8'h20, 32'd5, 3'd2, 8'h00, SYNC_B_RST,
                   8'(HEADER_BYTES), 32'd0);
        drive_word(1'b0, 8'h10, 8'h20, 32'd5, 3'd2, SYNC_A_RST, 8'hFF, 8'd255, 32'd0);
        // all-zero header: empty slots must not match it
        drive_word(1'b0, 8'h00, OWN_ID_RST, 32'd0, 3'd7, SYNC_A_RST, SYNC_B_RST,
                   8'(HEADER_BYTES), 32'd0);
        // just inside, then exactly at, the TTL
        drive_word(1'b0, 8'h00, OWN_ID_RST, 32'd0, 3'd7, SYNC_A_RST, SYNC_B_RST,
                   8'(HEADER_BYTES), TTL_RST - 32'd1);
        drive_word(1'b0, 8'h00, OWN_ID_RST, 32'd0, 3'd7, SYNC_A_RST, SYNC_B_RST,
                   8'(HEADER_BYTES), TTL_RST);
        // time running backwards looks ancient; broadcast with no hops left
        drive_word(1'b0, 8'h00, BCAST_RST, 32'd0, 3'd0, SYNC_A_RST, SYNC_B_RST,
                   8'd200, 32'hFFFF_FFFF);
        // another node's address: relay with one hop left
        drive_word(1'b0, 8'h5A, 8'd77, 32'h1234_5678, 3'd1, SYNC_A_RST, SYNC_B_RST,
                   8'd64, 32'd100);
        // sent note with junk in every ignored field, then its echo across the wrap
        drive_word(1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'h00, 8'h00, 8'd0,
                   32'hFFFF_FFF0);
        drive_word(1'b0, OWN_ID_RST, 8'h33, 32'hFFFF_FFFF, 3'd3, SYNC_A_RST, SYNC_B_RST,
                   8'd40, 32'h0000_0010);
        // same id from a different source is fresh
        drive_word(1'b0, 8'hFF, 8'h00, 32'hFFFF_FFFF, 3'd7, SYNC_A_RST, SYNC_B_RST,
                   8'd255, 32'h0000_0010);
        // broadcast that is both for us and relayed
        drive_word(1'b0, 8'hA5, BCAST_RST, 32'h8000_0001, 3'd7, SYNC_A_RST, SYNC_B_RST,
                   8'd12, 32'h0000_0020);
        drain();

        // Random phases, each with its own settings and idle pattern
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            configure_phase(ph);
            case (ph % 4)
                1: idle_pct = 47;
                3: idle_pct = 11;
                default: idle_pct = 0;
            endcase
            // one phase starts just short of the 32-bit wrap
            base_ms = (ph == 2) ? 32'hFFFF_F000 : $urandom;
            recent_q.delete();
            repeat (WORDS_PER_PHASE) random_word();
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("tb_mesh_packet_dedup_filter passed");
        else
            $display("tb_mesh_packet_dedup_filter failed");
        $finish;
    end

endmodule
